// File: sv/udp_ipv6_header_builder_core_assert.svh
// assertion macros for the header builder core
`ifndef UDP_IPV6_HEADER_BUILDER_CORE_ASSERT_SVH
`define UDP_IPV6_HEADER_BUILDER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define UDP6_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define UDP6_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/udp6_hdr_pkg.sv
`default_nettype none
package udp6_hdr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_ADDR_HI  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_ADDR_LO  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_ADDR_HI  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_ADDR_LO  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_PORT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_PORT     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_ANNO_DST = 3'd6;

   localparam logic [3:0]  IP_VERSION  = 4'd6;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam logic [7:0]  HOP_LIMIT   = 8'hff;
   localparam logic [16:0] MAX_PAYLOAD = 17'd65527;
   localparam logic [15:0] UDP_HDR_LEN = 16'd8;

   typedef struct packed {
      logic [63:0] src_addr_hi;
      logic [63:0] src_addr_lo;
      logic [63:0] dst_addr_hi;
      logic [63:0] dst_addr_lo;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        use_anno_dst;
   } cfg_type;

   typedef struct packed {
      logic [15:0] payload_sum;
      logic [15:0] udp_len;
      logic        too_long;
      logic [63:0] dst_hi;
      logic [63:0] dst_lo;
   } pkt_type;

endpackage
`default_nettype wire

// File: sv/udp6_hdr_csr.sv
`default_nettype none
module udp6_hdr_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write,
   input  logic [udp6_hdr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [udp6_hdr_pkg::CSR_DATA_W-1:0]     csr_data,
   output udp6_hdr_pkg::cfg_type                   cfg
);
   import udp6_hdr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SRC_ADDR_HI:  cfg_in.src_addr_hi  = csr_data;
            CSR_SRC_ADDR_LO:  cfg_in.src_addr_lo  = csr_data;
            CSR_DST_ADDR_HI:  cfg_in.dst_addr_hi  = csr_data;
            CSR_DST_ADDR_LO:  cfg_in.dst_addr_lo  = csr_data;
            CSR_SRC_PORT:     cfg_in.src_port     = csr_data[15:0];
            CSR_DST_PORT:     cfg_in.dst_port     = csr_data[15:0];
            CSR_USE_ANNO_DST: cfg_in.use_anno_dst = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// File: sv/udp6_hdr_accum.sv
`default_nettype none
module udp6_hdr_accum (
   input  logic                    clock,
   input  logic                    reset,
   input  udp6_hdr_pkg::cfg_type   cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_payload_byte,
   input  logic                    req_last_byte,
   input  logic [63:0]             req_anno_dst_hi,
   input  logic [63:0]             req_anno_dst_lo,
   output logic                    pkt_valid,
   output udp6_hdr_pkg::pkt_type   pkt,
   input  logic                    pkt_take
);
   import udp6_hdr_pkg::*;

   logic [15:0] run_ff, run_in;
   logic [16:0] cnt_ff, cnt_in;
   logic [7:0]  held_ff, held_in;
   logic        odd_ff, odd_in;
   logic        pkt_vld_ff, pkt_vld_in;
   pkt_type     pkt_ff, pkt_in;

   logic        accept;
   logic [16:0] add_word;
   logic [15:0] folded;
   logic [15:0] run_new;
   logic [7:0]  held_new;
   logic        odd_new;
   logic [16:0] add_pad;
   logic [15:0] pad_sum;
   logic [16:0] cnt_new;
   logic        too_long;
   logic [15:0] udp_len;

   assign req_stall = pkt_vld_ff & ~pkt_take;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      add_word = {1'b0, run_ff} + {1'b0, held_ff, req_payload_byte};
      folded   = add_word[15:0] + {15'd0, add_word[16]};
      run_new  = odd_ff ? folded : run_ff;
      held_new = odd_ff ? held_ff : req_payload_byte;
      odd_new  = ~odd_ff;
      // odd length: pad the waiting high byte with a zero low byte
      add_pad  = {1'b0, run_new} + {1'b0, held_new, 8'h00};
      pad_sum  = odd_new ? (add_pad[15:0] + {15'd0, add_pad[16]}) : run_new;
      cnt_new  = (cnt_ff <= MAX_PAYLOAD) ? (cnt_ff + 17'd1) : cnt_ff;
      too_long = cnt_new > MAX_PAYLOAD;
      udp_len  = too_long ? 16'hffff : (cnt_new[15:0] + UDP_HDR_LEN);
   end

   always_comb begin
      run_in     = run_ff;
      cnt_in     = cnt_ff;
      held_in    = held_ff;
      odd_in     = odd_ff;
      pkt_vld_in = pkt_vld_ff & ~pkt_take;
      pkt_in     = pkt_ff;
      if (accept) begin
         if (req_last_byte) begin
            run_in              = '0;
            cnt_in              = '0;
            held_in             = '0;
            odd_in              = 1'b0;
            pkt_vld_in          = 1'b1;
            pkt_in.payload_sum  = pad_sum;
            pkt_in.udp_len      = udp_len;
            pkt_in.too_long     = too_long;
            pkt_in.dst_hi       = cfg.use_anno_dst ? req_anno_dst_hi : cfg.dst_addr_hi;
            pkt_in.dst_lo       = cfg.use_anno_dst ? req_anno_dst_lo : cfg.dst_addr_lo;
         end else begin
            run_in  = run_new;
            cnt_in  = cnt_new;
            held_in = held_new;
            odd_in  = odd_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= '0;
         cnt_ff     <= '0;
         held_ff    <= '0;
         odd_ff     <= 1'b0;
         pkt_vld_ff <= 1'b0;
      end else begin
         run_ff     <= run_in;
         cnt_ff     <= cnt_in;
         held_ff    <= held_in;
         odd_ff     <= odd_in;
         pkt_vld_ff <= pkt_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in;
   end

   assign pkt_valid = pkt_vld_ff;
   assign pkt       = pkt_ff;

endmodule
`default_nettype wire

// File: sv/udp6_hdr_emit.sv
`default_nettype none
module udp6_hdr_emit (
   input  logic                    clock,
   input  logic                    reset,
   input  udp6_hdr_pkg::cfg_type   cfg,
   input  logic                    pkt_valid,
   input  udp6_hdr_pkg::pkt_type   pkt,
   output logic                    pkt_take,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [63:0]             rsp_header_word,
   output logic                    rsp_word_last,
   output logic                    rsp_too_long
);
   import udp6_hdr_pkg::*;

   localparam logic [2:0] WORD_SRC_HI = 3'd1;
   localparam logic [2:0] WORD_SRC_LO = 3'd2;
   localparam logic [2:0] WORD_DST_HI = 3'd3;
   localparam logic [2:0] WORD_DST_LO = 3'd4;
   localparam logic [2:0] WORD_UDP    = 3'd5;

   logic        busy_ff, busy_in;
   logic [2:0]  idx_ff, idx_in;
   logic [20:0] acc_ff, acc_in;
   logic [15:0] ulen_ff, ulen_in;
   logic        tl_ff, tl_in;
   logic [63:0] dhi_ff, dhi_in;
   logic [63:0] dlo_ff, dlo_in;
   logic        vld_ff, vld_in;
   logic [63:0] word_ff, word_in;
   logic        wlast_ff, wlast_in;

   logic        load_ok;
   logic [63:0] chunk;
   logic [20:0] acc_add;
   logic [20:0] acc_init;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] ck_raw;
   logic [15:0] ck;
   logic [63:0] w0;
   logic [63:0] w5;

   assign load_ok  = ~vld_ff | ~rsp_stall;
   assign pkt_take = ~busy_ff & pkt_valid & load_ok;

   always_comb begin
      case (idx_ff)
         WORD_SRC_HI: chunk = cfg.src_addr_hi;
         WORD_SRC_LO: chunk = cfg.src_addr_lo;
         WORD_DST_HI: chunk = dhi_ff;
         WORD_DST_LO: chunk = dlo_ff;
         default:     chunk = '0;
      endcase
      acc_add  = acc_ff + {5'd0, chunk[63:48]} + {5'd0, chunk[47:32]}
               + {5'd0, chunk[31:16]} + {5'd0, chunk[15:0]};
      acc_init = {5'd0, pkt.payload_sum} + {4'd0, pkt.udp_len, 1'b0}
               + {13'd0, PROTO_UDP} + {5'd0, cfg.src_port} + {5'd0, cfg.dst_port};
      fold1    = {1'b0, acc_ff[15:0]} + {12'd0, acc_ff[20:16]};
      fold2    = fold1[15:0] + {15'd0, fold1[16]};
      ck_raw   = ~fold2;
      ck       = (ck_raw == 16'd0) ? 16'hffff : ck_raw;
      w0       = {IP_VERSION, 28'd0, pkt.udp_len, PROTO_UDP, HOP_LIMIT};
      w5       = {cfg.src_port, cfg.dst_port, ulen_ff, ck};
   end

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      ulen_in  = ulen_ff;
      tl_in    = tl_ff;
      dhi_in   = dhi_ff;
      dlo_in   = dlo_ff;
      vld_in   = vld_ff & rsp_stall;
      word_in  = word_ff;
      wlast_in = wlast_ff;
      if (load_ok) begin
         if (busy_ff) begin
            vld_in   = 1'b1;
            acc_in   = acc_add;
            idx_in   = idx_ff + 3'd1;
            wlast_in = (idx_ff == WORD_UDP);
            word_in  = (idx_ff == WORD_UDP) ? w5 : chunk;
            if (idx_ff == WORD_UDP) begin
               busy_in = 1'b0;
            end
         end else if (pkt_valid) begin
            vld_in   = 1'b1;
            busy_in  = 1'b1;
            idx_in   = WORD_SRC_HI;
            acc_in   = acc_init;
            ulen_in  = pkt.udp_len;
            tl_in    = pkt.too_long;
            dhi_in   = pkt.dst_hi;
            dlo_in   = pkt.dst_lo;
            word_in  = w0;
            wlast_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      ulen_ff  <= ulen_in;
      tl_ff    <= tl_in;
      dhi_ff   <= dhi_in;
      dlo_ff   <= dlo_in;
      word_ff  <= word_in;
      wlast_ff <= wlast_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_header_word = word_ff;
   assign rsp_word_last   = wlast_ff;
   assign rsp_too_long    = tl_ff;

endmodule
`default_nettype wire

// File: sv/udp_ipv6_header_builder_core.sv
// Builds the 48-byte IPv6 plus UDP header for a packet whose payload arrives one
// byte per item, and sends it as six 64-bit big-endian words, the sixth marked
// by rsp_word_last. Payload bytes are taken at one per cycle while req_stall is
// low; the byte count and ones'-complement payload sum are updated in the cycle
// a byte is accepted. The last byte of a packet moves its totals into a one-entry
// packet slot, from which the emitter produces one header word per cycle while
// rsp_stall is low, folding the pseudo-header addresses into the checksum as it
// goes, and registers the first header word when it takes the packet. The input
// stalls while the slot holds a packet the emitter has not yet taken, which
// happens when a packet ends before the previous header has left or while the
// result side stalls, so back-to-back packets are paced by the emitter, which
// takes a new packet only once idle. Payloads longer than 65527 bytes report
// length 65535 and raise rsp_too_long on all six words.
// Configuration registers may only be written while no packet is in flight.
`default_nettype none
`include "udp_ipv6_header_builder_core_assert.svh"
module udp_ipv6_header_builder_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [7:0]                              req_payload_byte,
   input  logic                                    req_last_byte,
   input  logic [63:0]                             req_anno_dst_hi,
   input  logic [63:0]                             req_anno_dst_lo,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [63:0]                             rsp_header_word,
   output logic                                    rsp_word_last,
   output logic                                    rsp_too_long,
   input  logic                                    csr_write,
   input  logic [udp6_hdr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [udp6_hdr_pkg::CSR_DATA_W-1:0]     csr_data
);
   import udp6_hdr_pkg::*;

   cfg_type cfg;
   pkt_type pkt;
   logic    pkt_valid;
   logic    pkt_take;

   udp6_hdr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   udp6_hdr_accum u_accum (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_last_byte    (req_last_byte),
      .req_anno_dst_hi  (req_anno_dst_hi),
      .req_anno_dst_lo  (req_anno_dst_lo),
      .pkt_valid        (pkt_valid),
      .pkt              (pkt),
      .pkt_take         (pkt_take)
   );

   udp6_hdr_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .pkt_valid       (pkt_valid),
      .pkt             (pkt),
      .pkt_take        (pkt_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_header_word (rsp_header_word),
      .rsp_word_last   (rsp_word_last),
      .rsp_too_long    (rsp_too_long)
   );

   // slot handoff only from a filled slot
   `UDP6_ASSERT_NOW(a_take_needs_pkt, pkt_take, pkt_valid, "packet slot taken while empty")

   // input back-pressure only comes from a full slot
   `UDP6_ASSERT_NOW(a_stall_needs_pkt, req_stall, pkt_valid, "input stalled with empty slot")

   // an accepted final word is not followed directly by another final word
   `UDP6_ASSERT_NEXT(a_last_then_first, rsp_valid && !rsp_stall && rsp_word_last,
      !(rsp_valid && rsp_word_last), "two final header words in a row")

endmodule
`default_nettype wire

// File: verif/udp_ipv6_header_builder_core_test.sv
module udp_ipv6_header_builder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import udp6_hdr_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned PIPE_SETTLE  = 16;
   localparam int unsigned RANDOM_ITEMS = 230;
   localparam int unsigned IDLE_PCT     = 24;

   typedef struct packed {
      logic [63:0] word;
      logic        last;
      logic        too_long;
   } hdr_word_type;

   class header_scoreboard;
      cfg_type      cfg = '0;
      logic [15:0]  sum = '0;
      logic [16:0]  count = '0;
      logic [7:0]   held = '0;
      logic         odd = 1'b0;
      hdr_word_type expected_words[$];
      int unsigned  errors = 0;
      int unsigned  words_checked = 0;
      int unsigned  packets = 0;
      int unsigned  bytes_seen = 0;

      function logic [15:0] ones_add(logic [15:0] s, logic [15:0] w);
         logic [16:0] t;
         t = {1'b0, s} + {1'b0, w};
         return t[15:0] + {15'h0, t[16]};
      endfunction

      function logic [15:0] add_quad(logic [15:0] s, logic [63:0] v);
         logic [15:0] r;
         r = s;
         for (int i = 3; i >= 0; i--)
            r = ones_add(r, v[16*i +: 16]);
         return r;
      endfunction

      // pseudo-header and udp header folded onto a payload sum
      function logic [15:0] header_sum(logic [15:0] p, logic [15:0] ulen,
                                       logic [63:0] dhi, logic [63:0] dlo);
         logic [15:0] s;
         s = add_quad(p, cfg.src_addr_hi);
         s = add_quad(s, cfg.src_addr_lo);
         s = add_quad(s, dhi);
         s = add_quad(s, dlo);
         s = ones_add(s, ulen);
         s = ones_add(s, {8'h00, PROTO_UDP});
         s = ones_add(s, cfg.src_port);
         s = ones_add(s, cfg.dst_port);
         s = ones_add(s, ulen);
         return s;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_SRC_ADDR_HI:  cfg.src_addr_hi = val;
            CSR_SRC_ADDR_LO:  cfg.src_addr_lo = val;
            CSR_DST_ADDR_HI:  cfg.dst_addr_hi = val;
            CSR_DST_ADDR_LO:  cfg.dst_addr_lo = val;
            CSR_SRC_PORT:     cfg.src_port = val[15:0];
            CSR_DST_PORT:     cfg.dst_port = val[15:0];
            CSR_USE_ANNO_DST: cfg.use_anno_dst = val[0];
            default: ;
         endcase
      endfunction

      function void take_byte(logic [7:0] b, logic last, logic [63:0] ahi, logic [63:0] alo);
         logic [15:0] p;
         logic [15:0] ulen;
         logic [15:0] ck;
         logic        tl;
         logic [63:0] dhi;
         logic [63:0] dlo;
         bytes_seen++;
         if (odd) begin
            sum = ones_add(sum, {held, b});
            odd = 1'b0;
         end else begin
            held = b;
            odd = 1'b1;
         end
         if (count <= MAX_PAYLOAD)
            count = count + 17'd1;
         if (!last)
            return;
         p = sum;
         if (odd)
            p = ones_add(p, {held, 8'h00});
         tl = (count > MAX_PAYLOAD);
         ulen = tl ? 16'hffff : count[15:0] + UDP_HDR_LEN;
         dhi = cfg.use_anno_dst ? ahi : cfg.dst_addr_hi;
         dlo = cfg.use_anno_dst ? alo : cfg.dst_addr_lo;
         ck = ~header_sum(p, ulen, dhi, dlo);
         if (ck == 16'h0000)
            ck = 16'hffff;
         expected_words.push_back({{IP_VERSION, 28'h0, ulen, PROTO_UDP, HOP_LIMIT}, 1'b0, tl});
         expected_words.push_back({cfg.src_addr_hi, 1'b0, tl});
         expected_words.push_back({cfg.src_addr_lo, 1'b0, tl});
         expected_words.push_back({dhi, 1'b0, tl});
         expected_words.push_back({dlo, 1'b0, tl});
         expected_words.push_back({{cfg.src_port, cfg.dst_port, ulen, ck}, 1'b1, tl});
         sum = '0;
         count = '0;
         held = '0;
         odd = 1'b0;
         packets++;
      endfunction

      function void check_word(logic [63:0] w, logic wl, logic tl);
         hdr_word_type e;
         if (expected_words.size() == 0) begin
            $error("header word %h arrived with no packet pending", w);
            errors++;
            return;
         end
         e = expected_words.pop_front();
         words_checked++;
         if (w !== e.word) begin
            $error("header_word: expected %h, got %h", e.word, w);
            errors++;
         end
         if (wl !== e.last) begin
            $error("word_last: expected %b, got %b", e.last, wl);
            errors++;
         end
         if (tl !== e.too_long) begin
            $error("too_long: expected %b, got %b", e.too_long, tl);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_payload_byte = '0;
   logic                   req_last_byte = 1'b0;
   logic [63:0]            req_anno_dst_hi = '0;
   logic [63:0]            req_anno_dst_lo = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [63:0]            rsp_header_word;
   logic                   rsp_word_last;
   logic                   rsp_too_long;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic                   idle_on = 1'b1;
   int unsigned            hold_requests = 0;
   int unsigned            hold_served = 0;
   int unsigned            hold_left = 0;
   int unsigned            cycle_count = 0;
   int unsigned            csr_writes = 0;
   int unsigned            random_bytes = 0;

   header_scoreboard board = new();

   udp_ipv6_header_builder_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload_byte(req_payload_byte),
      .req_last_byte   (req_last_byte),
      .req_anno_dst_hi (req_anno_dst_hi),
      .req_anno_dst_lo (req_anno_dst_lo),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_header_word (rsp_header_word),
      .rsp_word_last   (rsp_word_last),
      .rsp_too_long    (rsp_too_long),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_header_word, rsp_word_last, rsp_too_long);
   end

   // receiver: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
   end

   function automatic logic [63:0] pick_word();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last,
                            input logic [63:0] ahi, input logic [63:0] alo);
      while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload_byte <= b;
      req_last_byte <= last;
      req_anno_dst_hi <= ahi;
      req_anno_dst_lo <= alo;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.take_byte(b, last, ahi, alo);
      @(negedge clock);
   endtask

   task automatic send_random_packet(input int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         send_byte(8'($urandom_range(255)), i == len - 1, {$urandom, $urandom},
                   {$urandom, $urandom});
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (board.pending() != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      board.write_reg(idx, val);
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic load_registers(input logic [63:0] shi, input logic [63:0] slo,
                                 input logic [63:0] dhi, input logic [63:0] dlo,
                                 input logic [63:0] sport, input logic [63:0] dport,
                                 input logic [63:0] anno);
      wait_drained();
      repeat (PIPE_SETTLE) @(negedge clock);
      write_csr(CSR_SRC_ADDR_HI, shi);
      write_csr(CSR_SRC_ADDR_LO, slo);
      write_csr(CSR_DST_ADDR_HI, dhi);
      write_csr(CSR_DST_ADDR_LO, dlo);
      write_csr(CSR_SRC_PORT, sport);
      write_csr(CSR_DST_PORT, dport);
      write_csr(CSR_USE_ANNO_DST, anno);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int unsigned group;
      int unsigned start;
      int unsigned len;
      logic        paused;
      logic [63:0] ahi;
      logic [63:0] alo;
      logic [15:0] crafted;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values, odd single byte padded
      send_byte(8'hff, 1'b1, '0, '0);

      load_registers('1, '1, '1, '1, '1, '1, 64'h0);
      send_byte(8'h00, 1'b0, '1, '1);
      send_byte(8'hff, 1'b1, '1, '1);
      for (int i = 0; i < 4; i++)
         send_byte(8'hff, i == 3, '0, '0);

      // annotation destination, sampled on the last item only
      load_registers('0, '0, '0, '0, '0, '0, 64'h1);
      send_byte(8'h00, 1'b1, '0, '0);
      send_byte(8'h5a, 1'b0, '0, '0);
      send_byte(8'ha5, 1'b0, '0, '0);
      send_byte(8'h3c, 1'b1, '1, '1);

      // payload chosen so the checksum computes to zero
      load_registers(pick_word(), pick_word(), pick_word(), pick_word(),
                     pick_word(), pick_word(), 64'h1);
      ahi = {$urandom, $urandom};
      alo = {$urandom, $urandom};
      crafted = ~board.header_sum(16'h0000, UDP_HDR_LEN + 16'd2, ahi, alo);
      send_byte(crafted[15:8], 1'b0, '0, '0);
      send_byte(crafted[7:0], 1'b1, ahi, alo);

      group = 0;
      while (random_bytes < RANDOM_ITEMS) begin
         if (group > 0)
            load_registers(pick_word(), pick_word(), pick_word(), pick_word(),
                           pick_word(), pick_word(), {$urandom, $urandom});
         idle_on <= (group != 1);
         if (group == 2)
            hold_requests <= hold_requests + 1;
         start = random_bytes;
         paused = 1'b0;
         while (random_bytes - start < 40) begin
            if (group == 3 && !paused && random_bytes - start >= 20) begin
               wait_drained();
               paused = 1'b1;
            end
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(8, 1);
            send_random_packet(len);
            random_bytes += len;
         end
         group++;
      end

      wait_drained();
      repeat (PIPE_SETTLE) @(negedge clock);
      $display("sent %0d packets, %0d payload bytes, odd and even lengths, both destinations",
               board.packets, board.bytes_seen);
      $display("checked %0d header words over %0d register writes", board.words_checked,
               csr_writes);
      if (board.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
